FILE: sv/lfu_pkg.sv
`timescale 1ns / 1ps
// shared codes and sizes for the lfu cache policy block
// no dependencies

package lfu_pkg;

  localparam int DATA_W         = 32;
  localparam int CAP_W          = 5;
  localparam int CAP_RESET      = 16;
  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_BUMP   = 2'd1,
    CMD_INSERT = 2'd2
  } cmd_kind_t;

endpackage

FILE: sv/lfu_cache_policy.sv
`timescale 1ns / 1ps
// top level of the lfu cache policy: request sequencer, entry cell row,
// result register; uses lfu_pkg and lfu_cell
//
// usage:
//   requests come in on in_valid / in_stall with in_opcode (get or put),
//   in_key and in_value; one result per request leaves on out_valid /
//   out_stall with out_hit, out_read_value, out_evicted, out_evicted_key.
//   one request is worked on at a time; in_stall is high while it is busy.
//   a get, a put that hits, or any put with capacity zero goes through
//   the look step to the update step, which registers out_valid; a put of
//   a new key also runs a search wave down the cell row in a scan step.
//   the next request is taken the cycle after the result is registered.
//   a waiting result does not block acceptance; a finished request only
//   holds in its update step while an older result is still stalled.
//   cfg_we writes cfg_wdata to capacity (values above ENTRIES act as ENTRIES).
//   reset clears all entries, occupancy and output valid, capacity to 16.

module lfu_cache_policy #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_opcode,
  input  logic [lfu_pkg::DATA_W-1:0] in_key,
  input  logic [lfu_pkg::DATA_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic [lfu_pkg::DATA_W-1:0] out_read_value,
  output logic                       out_evicted,
  output logic [lfu_pkg::DATA_W-1:0] out_evicted_key,
  input  logic                       cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_wdata
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CNT_W  = COUNT_BITS;
  localparam int CAND_W = 2 + 3 * IDX_W + CNT_W + lfu_pkg::DATA_W;

  typedef struct packed {
    logic                       vfound;
    logic [IDX_W-1:0]           vidx;
    logic [CNT_W-1:0]           vcnt;
    logic [IDX_W-1:0]           vrank;
    logic [lfu_pkg::DATA_W-1:0] vkey;
    logic                       ffound;
    logic [IDX_W-1:0]           fidx;
  } cand_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [lfu_pkg::CAP_W-1:0]  capacity_r;
  logic [OCC_W-1:0]           occ_r, occ_nxt;
  logic [OCC_W-1:0]           cap_eff;
  logic                       req_op_r;
  logic [lfu_pkg::DATA_W-1:0] req_key_r;
  logic [lfu_pkg::DATA_W-1:0] req_val_r;
  logic                       hit_r;
  logic [lfu_pkg::DATA_W-1:0] hval_r;
  logic [IDX_W-1:0]           hidx_r;
  logic [IDX_W-1:0]           hrank_r;
  logic [IDX_W-1:0]           scan_cnt_r;

  logic [ENTRIES-1:0]                       match;
  logic [ENTRIES-1:0][lfu_pkg::DATA_W-1:0]  cell_hval;
  logic [ENTRIES-1:0][IDX_W-1:0]            cell_hrank;
  logic [ENTRIES:0][CAND_W-1:0]             chain;

  logic                       any_hit;
  logic [lfu_pkg::DATA_W-1:0] hval_or;
  logic [IDX_W-1:0]           hrank_or;
  logic [IDX_W-1:0]           hidx_or;
  cand_t                      fin;
  logic                       upd_go;
  logic                       need_ins;
  logic                       do_evict;

  lfu_pkg::cmd_kind_t         cmd_kind;
  logic [IDX_W-1:0]           cmd_tgt;
  logic                       cmd_wr_val;
  logic [IDX_W-1:0]           cmd_ref_rank;

  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [lfu_pkg::DATA_W-1:0] out_read_value_r;
  logic                       out_evicted_r;
  logic [lfu_pkg::DATA_W-1:0] out_evicted_key_r;

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  assign cap_eff = (32'(capacity_r) > 32'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(capacity_r);

  assign chain[0] = '0;
  assign fin      = cand_t'(chain[ENTRIES]);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W),
      .CELL_IDX(g),
      .CAND_W  (CAND_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .req_key     (req_key_r),
      .cmd_kind    (cmd_kind),
      .cmd_tgt     (cmd_tgt),
      .cmd_key     (req_key_r),
      .cmd_value   (req_val_r),
      .cmd_wr_val  (cmd_wr_val),
      .cmd_ref_rank(cmd_ref_rank),
      .cmd_evict   (do_evict),
      .cand_i      (chain[g]),
      .cand_o      (chain[g+1]),
      .match       (match[g]),
      .hit_value   (cell_hval[g]),
      .hit_rank    (cell_hrank[g])
    );
  end

  // keys are unique, so at most one cell matches and an or picks it out
  always_comb begin
    hval_or  = '0;
    hrank_or = '0;
    hidx_or  = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      hval_or  = hval_or | cell_hval[k];
      hrank_or = hrank_or | cell_hrank[k];
      hidx_or  = hidx_or | (match[k] ? IDX_W'(k) : '0);
    end
  end
  assign any_hit = |match;

  assign need_ins = (req_op_r == lfu_pkg::OP_PUT) && (cap_eff != '0) && !hit_r;
  assign do_evict = need_ins && (occ_r >= cap_eff) && fin.vfound;
  assign upd_go   = (state_r == ST_UPD) && !(out_valid_r && out_stall);

  always_comb begin
    cmd_kind     = lfu_pkg::CMD_NONE;
    cmd_tgt      = hidx_r;
    cmd_wr_val   = (req_op_r == lfu_pkg::OP_PUT);
    cmd_ref_rank = hrank_r;
    occ_nxt      = occ_r;
    if (upd_go) begin
      if (hit_r && (req_op_r == lfu_pkg::OP_GET || cap_eff != '0)) begin
        cmd_kind = lfu_pkg::CMD_BUMP;
      end else if (need_ins) begin
        if (do_evict) begin
          cmd_kind     = lfu_pkg::CMD_INSERT;
          cmd_tgt      = fin.vidx;
          cmd_ref_rank = fin.vrank;
        end else if (fin.ffound) begin
          cmd_kind = lfu_pkg::CMD_INSERT;
          cmd_tgt  = fin.fidx;
          occ_nxt  = occ_r + OCC_W'(1);
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if ((req_op_r == lfu_pkg::OP_PUT) && (cap_eff != '0) && !any_hit) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capacity_r  <= lfu_pkg::CAP_W'(lfu_pkg::CAP_RESET);
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      scan_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (state_r == ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + IDX_W'(1);
      end else begin
        scan_cnt_r <= '0;
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_op_r  <= in_opcode;
      req_key_r <= in_key;
      req_val_r <= in_value;
    end
    if (state_r == ST_LOOK) begin
      hit_r   <= any_hit;
      hval_r  <= hval_or;
      hidx_r  <= hidx_or;
      hrank_r <= hrank_or;
    end
    if (upd_go) begin
      // a put with capacity zero reports nothing, not even a hit
      out_hit_r        <= hit_r && (req_op_r == lfu_pkg::OP_GET || cap_eff != '0);
      out_read_value_r <= (hit_r && req_op_r == lfu_pkg::OP_GET) ? hval_r : '1;
      out_evicted_r    <= do_evict;
      out_evicted_key_r <= do_evict ? fin.vkey : '0;
    end
  end

  a_onehot_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) |-> $onehot0(match))
    else $error("more than one entry matched the key");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(ENTRIES))
    else $error("occupancy above entry count");

  a_evict_found: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && need_ins && occ_r >= cap_eff) |-> fin.vfound)
    else $error("full cache but no victim found");

  a_result_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPD))
    else $error("result raised outside the update step");

endmodule

FILE: sv/lfu_cell.sv
`timescale 1ns / 1ps
// one cache entry: key, value, use count and recency rank, plus one stage
// of the victim / free-slot search chain; uses lfu_pkg

module lfu_cell #(
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 16,
  parameter int CELL_IDX = 0,
  parameter int CAND_W   = 2 + 3 * IDX_W + CNT_W + lfu_pkg::DATA_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lfu_pkg::DATA_W-1:0] req_key,
  input  lfu_pkg::cmd_kind_t        cmd_kind,
  input  logic [IDX_W-1:0]          cmd_tgt,
  input  logic [lfu_pkg::DATA_W-1:0] cmd_key,
  input  logic [lfu_pkg::DATA_W-1:0] cmd_value,
  input  logic                      cmd_wr_val,
  input  logic [IDX_W-1:0]          cmd_ref_rank,
  input  logic                      cmd_evict,
  input  logic [CAND_W-1:0]         cand_i,
  output logic [CAND_W-1:0]         cand_o,
  output logic                      match,
  output logic [lfu_pkg::DATA_W-1:0] hit_value,
  output logic [IDX_W-1:0]          hit_rank
);

  typedef struct packed {
    logic                       vfound;
    logic [IDX_W-1:0]           vidx;
    logic [CNT_W-1:0]           vcnt;
    logic [IDX_W-1:0]           vrank;
    logic [lfu_pkg::DATA_W-1:0] vkey;
    logic                       ffound;
    logic [IDX_W-1:0]           fidx;
  } cand_t;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                       valid_r;
  logic [lfu_pkg::DATA_W-1:0] key_r;
  logic [lfu_pkg::DATA_W-1:0] value_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [IDX_W-1:0]           rank_r;
  cand_t                      cand_in;
  cand_t                      cand_nxt;
  cand_t                      cand_r;
  logic                       is_tgt;

  assign is_tgt    = (cmd_tgt == MY_IDX);
  assign match     = valid_r && (key_r == req_key);
  assign hit_value = match ? value_r : '0;
  assign hit_rank  = match ? rank_r : '0;
  assign cand_in   = cand_t'(cand_i);
  assign cand_o    = CAND_W'(cand_r);

  // fold this entry into the running search result from the previous cell
  always_comb begin
    cand_nxt = cand_in;
    if (valid_r) begin
      if (!cand_in.vfound || cnt_r < cand_in.vcnt ||
          (cnt_r == cand_in.vcnt && rank_r > cand_in.vrank)) begin
        cand_nxt.vfound = 1'b1;
        cand_nxt.vidx   = MY_IDX;
        cand_nxt.vcnt   = cnt_r;
        cand_nxt.vrank  = rank_r;
        cand_nxt.vkey   = key_r;
      end
    end else if (!cand_in.ffound) begin
      cand_nxt.ffound = 1'b1;
      cand_nxt.fidx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (cmd_kind)
        lfu_pkg::CMD_BUMP: begin
          if (is_tgt) begin
            if (cmd_wr_val) begin
              value_r <= cmd_value;
            end
            if (cnt_r != '1) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
            rank_r <= '0;
          end else if (valid_r && rank_r < cmd_ref_rank) begin
            rank_r <= rank_r + IDX_W'(1);
          end
        end
        lfu_pkg::CMD_INSERT: begin
          if (is_tgt) begin
            valid_r <= 1'b1;
            key_r   <= cmd_key;
            value_r <= cmd_value;
            cnt_r   <= CNT_W'(1);
            rank_r  <= '0;
          end else if (valid_r && !(cmd_evict && rank_r > cmd_ref_rank)) begin
            // entries older than the victim close the gap and then age again
            rank_r <= rank_r + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
